FILE: hdl/rwsd_pkg.sv
// Shared constants and types of the register write stream deframer.
`default_nettype none
package rwsd_pkg;

  localparam logic [31:0] FrameMagic = 32'h5349_4446;
  localparam int HdrLen = 12;
  localparam int EvtLen = 8;
  localparam int HdrIdxW = $clog2(HdrLen);
  localparam int EvtIdxW = $clog2(EvtLen);

  typedef struct packed {
    logic        hit;
    logic [31:0] count;
  } hdr_stat_t;

  typedef struct packed {
    logic        wr_vld;
    logic [7:0]  addr;
    logic [7:0]  val;
    logic [31:0] delay;
    logic [31:0] frames;
    logic [31:0] writes;
    logic [31:0] bad_chip;
  } evt_res_t;

endpackage
`default_nettype wire

FILE: hdl/rwsd_hdr.sv
// Header search: 12-byte sliding window and magic match.
`default_nettype none
module rwsd_hdr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output rwsd_pkg::hdr_stat_t stat_o
);
  import rwsd_pkg::*;

  logic [7:0]         win_q [HdrLen-1];
  logic [7:0]         win_d [HdrLen-1];
  logic [HdrIdxW-1:0] fill_q, fill_d;
  logic               last, magic_ok, hit;

  assign last     = (fill_q == HdrIdxW'(HdrLen - 1));
  assign magic_ok = ({win_q[3], win_q[2], win_q[1], win_q[0]} == FrameMagic);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    hit    = 1'b0;
    if (step_i) begin
      if (last) begin
        if (magic_ok) begin
          hit    = 1'b1;
          fill_d = '0;
        end else begin
          for (int i = 0; i < HdrLen - 2; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[HdrLen-2] = byte_i;
        end
      end else begin
        win_d[fill_q] = byte_i;
        fill_d        = fill_q + HdrIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign stat_o.hit   = hit;
  assign stat_o.count = {win_q[7], win_q[6], win_q[5], win_q[4]};

endmodule
`default_nettype wire

FILE: hdl/rwsd_evt.sv
// Event assembly, chip filter and statistics counters.
`default_nettype none
module rwsd_evt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  rwsd_pkg::hdr_stat_t hdr_i,
  output logic                fin_o,
  output rwsd_pkg::evt_res_t  res_o
);
  import rwsd_pkg::*;

  logic [7:0]         ev_q [EvtLen-1];
  logic [7:0]         ev_d [EvtLen-1];
  logic [EvtIdxW-1:0] fill_q, fill_d;
  logic [31:0]        exp_q, exp_d;
  logic [31:0]        done_q, done_d;
  logic               skip_q, skip_d;
  logic [31:0]        frm_q, frm_d;
  logic [31:0]        wr_q, wr_d;
  logic [31:0]        bad_q, bad_d;
  logic               last, fin;

  assign last = (fill_q == EvtIdxW'(EvtLen - 1));

  always_comb begin
    ev_d   = ev_q;
    fill_d = fill_q;
    exp_d  = exp_q;
    done_d = done_q;
    skip_d = skip_q;
    frm_d  = frm_q;
    wr_d   = wr_q;
    bad_d  = bad_q;
    fin    = 1'b0;
    res_o.wr_vld = 1'b0;
    res_o.addr   = '0;
    res_o.val    = '0;
    res_o.delay  = '0;
    if (hdr_i.hit) begin
      exp_d  = hdr_i.count;
      done_d = '0;
      fill_d = '0;
      skip_d = (hdr_i.count == 32'd0);
      frm_d  = frm_q + 32'd1;
    end else if (step_i) begin
      if (last) begin
        fill_d = '0;
        if (done_q >= exp_q) begin
          fin = 1'b1;
        end else begin
          if (!skip_q) begin
            if (ev_q[0] != 8'd0) begin
              skip_d = 1'b1;
              bad_d  = bad_q + 32'd1;
            end else begin
              res_o.wr_vld = 1'b1;
              res_o.addr   = ev_q[1];
              res_o.val    = ev_q[2];
              res_o.delay  = {byte_i, ev_q[6], ev_q[5], ev_q[4]};
              wr_d         = wr_q + 32'd1;
            end
          end
          done_d = done_q + 32'd1;
          if (done_d >= exp_q) begin
            fin = 1'b1;
          end
        end
        if (fin) begin
          done_d = '0;
          skip_d = 1'b0;
        end
      end else begin
        ev_d[fill_q] = byte_i;
        fill_d       = fill_q + EvtIdxW'(1);
      end
    end
    res_o.frames   = frm_d;
    res_o.writes   = wr_d;
    res_o.bad_chip = bad_d;
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      exp_q  <= '0;
      done_q <= '0;
      skip_q <= 1'b0;
      frm_q  <= '0;
      wr_q   <= '0;
      bad_q  <= '0;
    end else begin
      fill_q <= fill_d;
      exp_q  <= exp_d;
      done_q <= done_d;
      skip_q <= skip_d;
      frm_q  <= frm_d;
      wr_q   <= wr_d;
      bad_q  <= bad_d;
    end
  end

  assign fin_o = fin;

endmodule
`default_nettype wire

FILE: hdl/register_write_stream_deframer_unit.sv
// Top level of the register write stream deframer.
// One stream byte is taken per transaction and every byte yields exactly one
// result transaction: a register write (chip 0 events) or an idle result with
// the three statistics counters. The block sustains one byte per clock while the
// result side is ready; a byte's result passes the input register, then the result
// register, and a stall on the result side can hold it between the two. Back-pressure
// on the result side stalls the input side only when both registers hold data. No
// clearing pass follows reset.
`default_nettype none
module register_write_stream_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [7:0]  reg_address_o,
  output logic [7:0]  reg_value_o,
  output logic [31:0] delay_cycles_o,
  output logic [31:0] frames_decoded_o,
  output logic [31:0] writes_forwarded_o,
  output logic [31:0] unsupported_chip_frames_o
);
  import rwsd_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       out_vld_q, out_vld_d;
  evt_res_t   res_q, res;
  logic       phase_q, phase_d;
  logic       step, in_acc, fin;
  hdr_stat_t  hdr_stat;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign in_acc     = in_valid_i && in_ready_o;

  rwsd_hdr u_hdr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step && !phase_q),
    .byte_i (byte_q),
    .stat_o (hdr_stat)
  );

  rwsd_evt u_evt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step && phase_q),
    .byte_i (byte_q),
    .hdr_i  (hdr_stat),
    .fin_o  (fin),
    .res_o  (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    phase_d = phase_q;
    if (hdr_stat.hit) begin
      phase_d = 1'b1;
    end else if (fin) begin
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= stream_byte_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o               = out_vld_q;
  assign write_valid_o             = res_q.wr_vld;
  assign reg_address_o             = res_q.addr;
  assign reg_value_o               = res_q.val;
  assign delay_cycles_o            = res_q.delay;
  assign frames_decoded_o          = res_q.frames;
  assign writes_forwarded_o        = res_q.writes;
  assign unsupported_chip_frames_o = res_q.bad_chip;

endmodule
`default_nettype wire

FILE: hdl/rwsd_chk.sv
// Port-level checker for the deframer top level, with its bind.
`default_nettype none
module rwsd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  stream_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_valid_o,
  input logic [7:0]  reg_address_o,
  input logic [7:0]  reg_value_o,
  input logic [31:0] delay_cycles_o,
  input logic [31:0] frames_decoded_o,
  input logic [31:0] writes_forwarded_o,
  input logic [31:0] unsupported_chip_frames_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(write_valid_o) && $stable(reg_address_o)
      && $stable(reg_value_o) && $stable(delay_cycles_o) && $stable(writes_forwarded_o))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> reg_address_o == 8'd0 && reg_value_o == 8'd0
      && delay_cycles_o == 32'd0)
    else $error("idle result carries write fields");

  a_wr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o |->
      writes_forwarded_o == $past(writes_forwarded_o) + 32'(write_valid_o))
    else $error("write counter out of step with writes");

  a_no_frame_and_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && write_valid_o |->
      frames_decoded_o == $past(frames_decoded_o)
      && unsupported_chip_frames_o == $past(unsupported_chip_frames_o))
    else $error("write result also moved frame counters");

endmodule

bind register_write_stream_deframer_unit rwsd_chk u_rwsd_chk (.*);
`default_nettype wire

FILE: dv/tb_register_write_stream_deframer_unit.sv
// Self-checking testbench of the register write stream deframer: byte stream in, checked writes out.
`timescale 1ns / 100ps
module tb_register_write_stream_deframer_unit;
  import rwsd_pkg::*;

  localparam int StallLimit = 1000;
  localparam int RandomBytes = 1850;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    evt_res_t   res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_valid_o;
  logic [7:0]  reg_address_o;
  logic [7:0]  reg_value_o;
  logic [31:0] delay_cycles_o;
  logic [31:0] frames_decoded_o;
  logic [31:0] writes_forwarded_o;
  logic [31:0] unsupported_chip_frames_o;

  logic        idle_on = 1'b1;
  logic        row_typed = 1'b0;
  evt_res_t    row_res = '0;
  int          fails = 0;
  int          stall_cycles = 0;
  int          bytes_sent = 0;
  evt_res_t    predicted_results[$];

  // predictor state
  logic        ev_phase = 1'b0;
  logic [7:0]  hdr_win [HdrLen];
  int unsigned hdr_cnt = 0;
  logic [31:0] evt_total = '0;
  logic [7:0]  evt_buf [EvtLen];
  int unsigned evt_cnt = 0;
  logic [31:0] evt_seen = '0;
  logic        skipping = 1'b0;
  logic [31:0] n_frames = '0;
  logic [31:0] n_writes = '0;
  logic [31:0] n_bad = '0;

  // noise, then a one-event frame whose write uses the field extremes
  row_t plan [22] = '{
    '{8'hFF, 1'b1, '0},
    '{8'h00, 1'b1, '0},
    '{8'h46, 1'b0, '0}, '{8'h44, 1'b0, '0}, '{8'h49, 1'b0, '0}, '{8'h53, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hA5, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{1'b1, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0}}
  };

  register_write_stream_deframer_unit dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic void go_header();
    ev_phase = 1'b0;
    hdr_cnt = 0;
    evt_cnt = 0;
    evt_seen = '0;
    skipping = 1'b0;
  endfunction

  function automatic evt_res_t deframe_byte(input logic [7:0] b);
    evt_res_t r;
    int i;
    r = '0;
    if (!ev_phase) begin
      if (hdr_cnt >= HdrLen) hdr_cnt = HdrLen - 1;
      hdr_win[hdr_cnt] = b;
      hdr_cnt++;
      if (hdr_cnt >= HdrLen) begin
        if ({hdr_win[3], hdr_win[2], hdr_win[1], hdr_win[0]} != FrameMagic) begin
          for (i = 0; i < HdrLen - 1; i++) hdr_win[i] = hdr_win[i + 1];
          hdr_cnt = HdrLen - 1;
        end else begin
          evt_total = {hdr_win[7], hdr_win[6], hdr_win[5], hdr_win[4]};
          evt_seen = '0;
          evt_cnt = 0;
          ev_phase = 1'b1;
          skipping = (evt_total == 0);
          n_frames++;
        end
      end
    end else begin
      if (evt_cnt >= EvtLen) evt_cnt = EvtLen - 1;
      evt_buf[evt_cnt] = b;
      evt_cnt++;
      if (evt_cnt >= EvtLen) begin
        if (evt_seen >= evt_total) begin
          go_header();
        end else begin
          if (!skipping) begin
            if (evt_buf[0] != 8'h00) begin
              skipping = 1'b1;
              n_bad++;
            end else begin
              r.wr_vld = 1'b1;
              r.addr = evt_buf[1];
              r.val = evt_buf[2];
              r.delay = {evt_buf[7], evt_buf[6], evt_buf[5], evt_buf[4]};
              n_writes++;
            end
          end
          evt_seen++;
          evt_cnt = 0;
          if (evt_seen >= evt_total) go_header();
        end
      end
    end
    r.frames = n_frames;
    r.writes = n_writes;
    r.bad_chip = n_bad;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i) out_ready_i <= !idle_on || ($urandom_range(0, 99) >= 11);

  // transaction monitor, predictor and watchdog
  always @(posedge clk_i) begin : mon
    evt_res_t r;
    logic acc;
    if (rst_ni) begin
      acc = 1'b0;
      if (in_valid_i && in_ready_o) begin
        r = deframe_byte(stream_byte_i);
        if (row_typed) r = row_res;
        predicted_results.push_back(r);
        acc = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        acc = 1'b1;
        if (predicted_results.size() == 0) begin
          $error("result with no transaction pending");
          fails++;
        end else begin
          r = predicted_results.pop_front();
          check_field("write_valid", 32'(r.wr_vld), 32'(write_valid_o));
          check_field("reg_address", 32'(r.addr), 32'(reg_address_o));
          check_field("reg_value", 32'(r.val), 32'(reg_value_o));
          check_field("delay_cycles", r.delay, delay_cycles_o);
          check_field("frames_decoded", r.frames, frames_decoded_o);
          check_field("writes_forwarded", r.writes, writes_forwarded_o);
          check_field("unsupported_chip_frames", r.bad_chip, unsupported_chip_frames_o);
        end
      end
      stall_cycles = acc ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic typed, input evt_res_t res);
    while (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    row_typed <= typed;
    row_res <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_chunk();
    int kind;
    int n;
    int i;
    logic [31:0] cnt;
    logic [31:0] dly;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else if (kind < 14) begin
      // magic prefix cut short
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_byte(FrameMagic[8*i +: 8], 1'b0, '0);
      push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      kind = $urandom_range(0, 99);
      cnt = (kind < 15) ? 32'd0 : (kind < 95) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      for (i = 0; i < 4; i++) push_byte(FrameMagic[8*i +: 8], 1'b0, '0);
      for (i = 0; i < 4; i++) push_byte(cnt[8*i +: 8], 1'b0, '0);
      for (i = 0; i < 4; i++) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      n = (cnt == 0) ? 1 : int'(cnt);
      repeat (n) begin
        push_byte(($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)),
                  1'b0, '0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        dly = $urandom;
        for (i = 0; i < 4; i++) push_byte(dly[8*i +: 8], 1'b0, '0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[k]) push_byte(plan[k].b, plan[k].typed, plan[k].res);
    drain();
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      if (bytes_sent > 700 && bytes_sent < 1100) idle_on <= 1'b0;
      else idle_on <= 1'b1;
      if (bytes_sent > 1400 && bytes_sent < 1440) drain();
      send_chunk();
    end
    drain();
    repeat (6) @(posedge clk_i);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
